/* src/single_bin_dft_three_axis_macros.svh */
// Assertion macros shared by the single-bin DFT block.
`ifndef SINGLE_BIN_DFT_THREE_AXIS_MACROS_SVH
`define SINGLE_BIN_DFT_THREE_AXIS_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define SBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define SBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBD_ASSERT(lbl, prop, msg)
`define SBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/sbd_pkg.sv */
// Shared types, constants and tables of the single-bin DFT block.
`timescale 1ns / 1ps
`default_nettype none
package sbd_pkg;
  localparam int COUNT_BITS = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int AXES = 3;

  localparam int TIME_BITS = 24;
  localparam int FREQ_BITS = 20;
  localparam int FIELD_BITS = 16;
  localparam int OUT_BITS = 24;
  localparam int SUM_BITS = 56;
  localparam int TRIG_BITS = 16;
  localparam int PROD_BITS = SAMPLE_BITS + TRIG_BITS;
  localparam int VEC_BITS = 60;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_BITS = 5;
  localparam int ROT_BITS = 34;

  localparam int DIV_BITS = 62;
  localparam int DVSR_BITS = (COUNT_BITS + 6 > 30) ? COUNT_BITS + 6 : 30;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam logic [29:0] GAIN_INV = 30'd652032874;
  localparam logic [29:0] NS_PER_TURN = 30'd1000000000;
  localparam logic [FREQ_BITS-1:0] FREQ_RESET = 20'd50000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  // Reciprocals for the phase reduction: floor(2^50 / 10^9), the odd part of
  // 10^9, and floor(2^52 / that odd part).
  localparam logic [20:0] MOD_RECIP = 21'd1125899;
  localparam logic [20:0] PH_DIV = 21'd1953125;
  localparam logic [31:0] PH_RECIP = 32'd2305843009;

  typedef struct packed {
    logic [TIME_BITS-1:0]         sample_time_us;
    logic signed [FIELD_BITS-1:0] accel_x;
    logic signed [FIELD_BITS-1:0] accel_y;
    logic signed [FIELD_BITS-1:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] sample_count;
    logic [OUT_BITS-1:0] mag_x;
    logic [OUT_BITS-1:0] mag_y;
    logic [OUT_BITS-1:0] mag_z;
  } out_word_t;

  // Command from the sequencer to every axis lane.
  typedef struct packed {
    logic                        start;
    logic                        accum;
    logic signed [TRIG_BITS-1:0] sin_v;
    logic signed [TRIG_BITS-1:0] cos_v;
    logic [COUNT_BITS-1:0]       count;
  } lane_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_MOD, ST_MODFIX, ST_PHQ, ST_PHFIX,
    ST_TRIG, ST_TRIGW, ST_LSTART, ST_LWAIT, ST_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    LS_IDLE, LS_ACC, LS_LOAD, LS_VEC, LS_DIV1, LS_DIV1W,
    LS_DIV2, LS_DIV2W, LS_MUL, LS_SUM
  } lane_state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [STEP_BITS-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* src/sbd_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sbd_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [sbd_pkg::DIV_BITS-1:0]   dividend,
  input  wire logic [sbd_pkg::DVSR_BITS-1:0]  divisor,
  output logic                                done,
  output logic [sbd_pkg::DIV_BITS-1:0]        quotient,
  output logic [sbd_pkg::DVSR_BITS-1:0]       remainder
);
  logic [sbd_pkg::DVSR_BITS-1:0]    dvsr;
  logic [sbd_pkg::DIV_CNT_BITS-1:0] cnt;
  logic                             run;
  logic [sbd_pkg::DVSR_BITS:0]      trial;
  logic                             ge;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {remainder, quotient[sbd_pkg::DIV_BITS-1]};
  assign ge = (trial >= {1'b0, dvsr});

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == sbd_pkg::DIV_CNT_BITS'(sbd_pkg::DIV_BITS - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dvsr <= divisor;
    end else if (run) begin
      if (ge) begin
        remainder <= sbd_pkg::DVSR_BITS'(trial - {1'b0, dvsr});
      end else begin
        remainder <= trial[sbd_pkg::DVSR_BITS-1:0];
      end
      quotient <= {quotient[sbd_pkg::DIV_BITS-2:0], ge};
    end
  end
endmodule
`default_nettype wire

/* src/sbd_sincos.sv */
// Rotation CORDIC giving the Q1.15 sine and cosine of a phase in turns.
`timescale 1ns / 1ps
`default_nettype none
module sbd_sincos (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [31:0]                          phase,
  output logic                                      done,
  output logic signed [sbd_pkg::TRIG_BITS-1:0]      sin_v,
  output logic signed [sbd_pkg::TRIG_BITS-1:0]      cos_v
);
  logic signed [sbd_pkg::ROT_BITS-1:0] x;
  logic signed [sbd_pkg::ROT_BITS-1:0] y;
  logic signed [sbd_pkg::ROT_BITS-1:0] z;
  logic [sbd_pkg::STEP_BITS-1:0]       step;
  logic                                run;
  logic                                flip;
  logic                                fin;
  logic signed [sbd_pkg::ROT_BITS-1:0] atan_v;
  logic signed [sbd_pkg::ROT_BITS-1:0] xo;
  logic signed [sbd_pkg::ROT_BITS-1:0] yo;

  // Round Q2.30 to Q1.15 and clamp to the symmetric range.
  function automatic logic signed [sbd_pkg::TRIG_BITS-1:0] to_q15(
    input logic signed [sbd_pkg::ROT_BITS-1:0] v);
    logic signed [sbd_pkg::ROT_BITS:0] t;
    logic signed [sbd_pkg::ROT_BITS:0] r;
    logic signed [sbd_pkg::TRIG_BITS-1:0] o;
    t = (sbd_pkg::ROT_BITS+1)'(v) + 35'sd16384;
    r = t >>> 15;
    if (r > 35'sd32767) begin
      o = 16'sd32767;
    end else if (r < -35'sd32767) begin
      o = -16'sd32767;
    end else begin
      o = r[sbd_pkg::TRIG_BITS-1:0];
    end
    return o;
  endfunction

  assign atan_v = sbd_pkg::ROT_BITS'(sbd_pkg::atan_turn(step));
  assign fin = run && (step == sbd_pkg::STEP_BITS'(sbd_pkg::CORDIC_STEPS - 1));

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= fin;
      if (start) begin
        run <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (fin) begin
          run <= 1'b0;
        end
      end
    end
  end

  // The current micro-rotation; on the last step the outputs take it, negated by the half-turn flip where it applies.
  always_comb begin
    if (z >= 0) begin
      xo = x - (y >>> step);
      yo = y + (x >>> step);
    end else begin
      xo = x + (y >>> step);
      yo = y - (x >>> step);
    end
  end

  // Datapath: half-turn reduction, then one micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= phase[31] ^ phase[30];
      x <= sbd_pkg::ROT_BITS'(sbd_pkg::GAIN_INV);
      y <= '0;
      if (phase[31] ^ phase[30]) begin
        z <= sbd_pkg::ROT_BITS'(signed'(phase ^ 32'h80000000));
      end else begin
        z <= sbd_pkg::ROT_BITS'(signed'(phase));
      end
    end else if (run) begin
      x <= xo;
      y <= yo;
      if (z >= 0) begin
        z <= z - atan_v;
      end else begin
        z <= z + atan_v;
      end
      if (fin) begin
        sin_v <= flip ? to_q15(-yo) : to_q15(yo);
        cos_v <= flip ? to_q15(-xo) : to_q15(xo);
      end
    end
  end
endmodule
`default_nettype wire

/* src/sbd_lane.sv */
// One axis lane: complex accumulator, modulus CORDIC and scaling by the count.
`timescale 1ns / 1ps
`default_nettype none
module sbd_lane (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sbd_pkg::lane_cmd_t                  cmd,
  input  wire logic signed [sbd_pkg::FIELD_BITS-1:0] accel,
  output logic                                     done,
  output logic [sbd_pkg::OUT_BITS-1:0]             mag
);
  sbd_pkg::lane_state_t state, state_next;

  logic signed [sbd_pkg::SUM_BITS-1:0]    sum_sine_part;
  logic signed [sbd_pkg::SUM_BITS-1:0]    sum_cosine_part;
  logic signed [sbd_pkg::SAMPLE_BITS-1:0] smp;
  logic signed [sbd_pkg::TRIG_BITS-1:0]   sin_r;
  logic signed [sbd_pkg::TRIG_BITS-1:0]   cos_r;
  logic                                   accum;
  logic [sbd_pkg::COUNT_BITS-1:0]         count;
  logic signed [sbd_pkg::VEC_BITS-1:0]    x;
  logic signed [sbd_pkg::VEC_BITS-1:0]    y;
  logic [sbd_pkg::STEP_BITS-1:0]          step;
  logic [sbd_pkg::DIV_BITS-1:0]           quo_a;
  logic [sbd_pkg::DVSR_BITS-1:0]          rem_r;
  logic [19:0]                            quo_q;
  logic [55:0]                            p1;
  logic [49:0]                            p2;
  logic [56:0]                            vsum;
  logic                                   vec_last;
  logic                                   a_big;

  logic                                   div_start;
  logic [sbd_pkg::DIV_BITS-1:0]           div_dividend;
  logic [sbd_pkg::DVSR_BITS-1:0]          div_divisor;
  logic                                   div_done;
  logic [sbd_pkg::DIV_BITS-1:0]           div_quo;
  logic [sbd_pkg::DVSR_BITS-1:0]          div_rem;

  logic signed [sbd_pkg::PROD_BITS-1:0]   prod_s;
  logic signed [sbd_pkg::PROD_BITS-1:0]   prod_c;
  logic signed [sbd_pkg::SUM_BITS:0]      add_s;
  logic signed [sbd_pkg::SUM_BITS:0]      add_c;

  assign smp = sbd_pkg::SAMPLE_BITS'(accel);
  assign vec_last = (step == sbd_pkg::STEP_BITS'(sbd_pkg::CORDIC_STEPS - 1));
  assign a_big = |div_quo[sbd_pkg::DIV_BITS-1:26];
  assign div_divisor = sbd_pkg::DVSR_BITS'(count) << 6;

  // Products and widened sums for the saturating accumulate.
  assign prod_s = sbd_pkg::PROD_BITS'(smp) * sbd_pkg::PROD_BITS'(sin_r);
  assign prod_c = sbd_pkg::PROD_BITS'(smp) * sbd_pkg::PROD_BITS'(cos_r);
  assign add_s = (sbd_pkg::SUM_BITS+1)'(sum_sine_part) + (sbd_pkg::SUM_BITS+1)'(prod_s);
  assign add_c = (sbd_pkg::SUM_BITS+1)'(sum_cosine_part) + (sbd_pkg::SUM_BITS+1)'(prod_c);

  // Sum of the two scaled partial products.
  assign vsum = 57'(p1) + 57'(p2 >> 20);

  sbd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbd_pkg::LS_IDLE:  if (cmd.start) state_next = sbd_pkg::LS_ACC;
      sbd_pkg::LS_ACC:   state_next = sbd_pkg::LS_LOAD;
      sbd_pkg::LS_LOAD:  state_next = sbd_pkg::LS_VEC;
      sbd_pkg::LS_VEC: begin
        if (vec_last) begin
          state_next = (count == '0) ? sbd_pkg::LS_IDLE : sbd_pkg::LS_DIV1;
        end
      end
      sbd_pkg::LS_DIV1:  state_next = sbd_pkg::LS_DIV1W;
      sbd_pkg::LS_DIV1W: begin
        if (div_done) begin
          state_next = a_big ? sbd_pkg::LS_IDLE : sbd_pkg::LS_DIV2;
        end
      end
      sbd_pkg::LS_DIV2:  state_next = sbd_pkg::LS_DIV2W;
      sbd_pkg::LS_DIV2W: if (div_done) state_next = sbd_pkg::LS_MUL;
      sbd_pkg::LS_MUL:   state_next = sbd_pkg::LS_SUM;
      sbd_pkg::LS_SUM:   state_next = sbd_pkg::LS_IDLE;
      default:           state_next = sbd_pkg::LS_IDLE;
    endcase
  end

  // Divider requests: modulus over the scaled count, then the fraction.
  always_comb begin
    div_start = 1'b0;
    div_dividend = sbd_pkg::DIV_BITS'(x[57:0]);
    case (state)
      sbd_pkg::LS_DIV1: begin
        div_start = 1'b1;
      end
      sbd_pkg::LS_DIV2: begin
        div_start = 1'b1;
        div_dividend = sbd_pkg::DIV_BITS'({rem_r, 20'b0});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbd_pkg::LS_IDLE;
      done <= 1'b0;
      step <= '0;
      sum_sine_part <= '0;
      sum_cosine_part <= '0;
    end else begin
      state <= state_next;
      if (cmd.start && state == sbd_pkg::LS_IDLE) begin
        done <= 1'b0;
      end
      if (state == sbd_pkg::LS_ACC && accum) begin
        if (add_s[sbd_pkg::SUM_BITS] != add_s[sbd_pkg::SUM_BITS-1]) begin
          sum_sine_part <= add_s[sbd_pkg::SUM_BITS] ?
            {1'b1, {(sbd_pkg::SUM_BITS-1){1'b0}}} : {1'b0, {(sbd_pkg::SUM_BITS-1){1'b1}}};
        end else begin
          sum_sine_part <= add_s[sbd_pkg::SUM_BITS-1:0];
        end
        if (add_c[sbd_pkg::SUM_BITS] != add_c[sbd_pkg::SUM_BITS-1]) begin
          sum_cosine_part <= add_c[sbd_pkg::SUM_BITS] ?
            {1'b1, {(sbd_pkg::SUM_BITS-1){1'b0}}} : {1'b0, {(sbd_pkg::SUM_BITS-1){1'b1}}};
        end else begin
          sum_cosine_part <= add_c[sbd_pkg::SUM_BITS-1:0];
        end
      end
      if (state == sbd_pkg::LS_LOAD) begin
        step <= '0;
      end else if (state == sbd_pkg::LS_VEC) begin
        step <= step + 1'b1;
      end
      if ((state == sbd_pkg::LS_VEC && vec_last && count == '0) ||
          (state == sbd_pkg::LS_DIV1W && div_done && a_big) ||
          (state == sbd_pkg::LS_SUM)) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      sbd_pkg::LS_IDLE: begin
        sin_r <= cmd.sin_v;
        cos_r <= cmd.cos_v;
        accum <= cmd.accum;
        count <= cmd.count;
      end
      sbd_pkg::LS_LOAD: begin
        x <= (sum_sine_part < 0) ? -sbd_pkg::VEC_BITS'(sum_sine_part)
                                 : sbd_pkg::VEC_BITS'(sum_sine_part);
        y <= (sum_cosine_part < 0) ? -sbd_pkg::VEC_BITS'(sum_cosine_part)
                                   : sbd_pkg::VEC_BITS'(sum_cosine_part);
      end
      sbd_pkg::LS_VEC: begin
        if (y >= 0) begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
        end else begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
        end
        if (vec_last && count == '0) begin
          mag <= '0;
        end
      end
      sbd_pkg::LS_DIV1W: begin
        quo_a <= div_quo;
        rem_r <= div_rem;
        if (div_done && a_big) begin
          mag <= sbd_pkg::OUT_MAX;
        end
      end
      sbd_pkg::LS_DIV2W: begin
        quo_q <= div_quo[19:0];
      end
      sbd_pkg::LS_MUL: begin
        p1 <= quo_a[25:0] * sbd_pkg::GAIN_INV;
        p2 <= quo_q * sbd_pkg::GAIN_INV;
      end
      sbd_pkg::LS_SUM: begin
        mag <= (|vsum[56:54]) ? sbd_pkg::OUT_MAX : vsum[53:30];
      end
      default: begin
        count <= count;
      end
    endcase
  end
endmodule
`default_nettype wire

/* src/single_bin_dft_three_axis.sv */
// Top level of the single-bin DFT tracker: phase sequencer, axis lanes, result merge.
//
//   channel  direction  payload     handshake
//   in       input      in_word_t   in_valid / in_ready
//   out      output     out_word_t  out_valid / out_ready
//   cfg      input      frequency   cfg_valid / cfg_ready (always ready)
//
// Each accumulated word passes through phase reduction by reciprocal multiplication, the
// sine/cosine CORDIC and the lanes, which run the 24-step modulus CORDIC and two 62-step
// divisions by the scaled count on a one-bit divider. A new word is taken only once the
// last one has left the lanes. The three lanes run in lockstep.
// Synchronous reset clears the sums, the count and the frequency to 50000 mHz.
// A new word is taken while a finished result still waits on out_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "single_bin_dft_three_axis_macros.svh"
module single_bin_dft_three_axis (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire sbd_pkg::in_word_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output sbd_pkg::out_word_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sbd_pkg::FREQ_BITS-1:0]    cfg_data
);
  sbd_pkg::top_state_t state, state_next;

  logic [sbd_pkg::FREQ_BITS-1:0]  frequency;
  logic [sbd_pkg::COUNT_BITS-1:0] count;
  logic                           accum;
  sbd_pkg::in_word_t              word;
  logic [43:0]                    prod;
  logic [44:0]                    mod_p;
  logic [14:0]                    mod_q;
  logic [44:0]                    mod_sub;
  logic [44:0]                    mod_rem;
  logic [44:0]                    mod_adj;
  logic                           mod_ge;
  logic [29:0]                    ph_rem;
  logic [61:0]                    ph_p;
  logic [31:0]                    ph_q;
  logic [52:0]                    ph_sub;
  logic [52:0]                    ph_res;
  logic                           ph_ge;
  logic [31:0]                    phase;

  logic                           trig_start;
  logic                           trig_done;
  logic signed [sbd_pkg::TRIG_BITS-1:0] sin_v;
  logic signed [sbd_pkg::TRIG_BITS-1:0] cos_v;

  sbd_pkg::lane_cmd_t             cmd;
  logic [sbd_pkg::AXES-1:0]       lane_done;
  logic [sbd_pkg::OUT_BITS-1:0]   lane_mag [sbd_pkg::AXES];
  logic signed [sbd_pkg::FIELD_BITS-1:0] lane_accel [sbd_pkg::AXES];
  logic [sbd_pkg::OUT_BITS-1:0]   mag_all [3];
  logic [31:0]                    count_w;
  logic                           out_free;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == sbd_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign count_w = 32'(count);

  // Product modulo 10^9: the quotient estimate from the top bits is low by at most one.
  assign mod_p = 45'(prod[43:20]) * 45'(sbd_pkg::MOD_RECIP);
  assign mod_sub = 45'(mod_q) * 45'(sbd_pkg::NS_PER_TURN);
  assign mod_rem = 45'(prod) - mod_sub;
  assign mod_adj = mod_rem - 45'(sbd_pkg::NS_PER_TURN);
  assign mod_ge = (mod_rem >= 45'(sbd_pkg::NS_PER_TURN));

  // Turn fraction rem * 2^23 / 1953125: the estimate is low by at most one.
  assign ph_p = 62'(ph_rem) * 62'(sbd_pkg::PH_RECIP);
  assign ph_sub = 53'(ph_q) * 53'(sbd_pkg::PH_DIV);
  assign ph_res = {ph_rem, 23'b0} - ph_sub;
  assign ph_ge = (ph_res >= 53'(sbd_pkg::PH_DIV));

  sbd_sincos u_sincos (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .phase (phase),
    .done  (trig_done),
    .sin_v (sin_v),
    .cos_v (cos_v)
  );

  // Lane samples in axis order.
  assign lane_accel[0] = word.accel_x;
  if (sbd_pkg::AXES > 1) begin : g_ay
    assign lane_accel[1] = word.accel_y;
  end
  if (sbd_pkg::AXES > 2) begin : g_az
    assign lane_accel[2] = word.accel_z;
  end

  for (genvar a = 0; a < sbd_pkg::AXES; a++) begin : g_lane
    sbd_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .accel (lane_accel[a]),
      .done  (lane_done[a]),
      .mag   (lane_mag[a])
    );
  end

  // Merge: missing axes read as zero.
  for (genvar a = 0; a < 3; a++) begin : g_merge
    if (a < sbd_pkg::AXES) begin : g_used
      assign mag_all[a] = lane_mag[a];
    end else begin : g_unused
      assign mag_all[a] = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sbd_pkg::ST_MUL;
        end
      end
      sbd_pkg::ST_MUL:    state_next = accum ? sbd_pkg::ST_MOD : sbd_pkg::ST_LSTART;
      sbd_pkg::ST_MOD:    state_next = sbd_pkg::ST_MODFIX;
      sbd_pkg::ST_MODFIX: state_next = sbd_pkg::ST_PHQ;
      sbd_pkg::ST_PHQ:    state_next = sbd_pkg::ST_PHFIX;
      sbd_pkg::ST_PHFIX:  state_next = sbd_pkg::ST_TRIG;
      sbd_pkg::ST_TRIG:   state_next = sbd_pkg::ST_TRIGW;
      sbd_pkg::ST_TRIGW:  if (trig_done) state_next = sbd_pkg::ST_LSTART;
      sbd_pkg::ST_LSTART: state_next = sbd_pkg::ST_LWAIT;
      sbd_pkg::ST_LWAIT:  if (&lane_done) state_next = sbd_pkg::ST_OUT;
      sbd_pkg::ST_OUT:    if (out_free) state_next = sbd_pkg::ST_IDLE;
      default:            state_next = sbd_pkg::ST_IDLE;
    endcase
  end

  // Unit requests and the lane command.
  always_comb begin
    trig_start = (state == sbd_pkg::ST_TRIG);
    cmd.start = (state == sbd_pkg::ST_LSTART);
    cmd.accum = accum;
    cmd.sin_v = sin_v;
    cmd.cos_v = cos_v;
    cmd.count = count + sbd_pkg::COUNT_BITS'(accum);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbd_pkg::ST_IDLE;
      frequency <= sbd_pkg::FREQ_RESET;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        frequency <= cfg_data;
      end
      if (state == sbd_pkg::ST_LSTART) begin
        count <= cmd.count;
      end
      if (state == sbd_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == sbd_pkg::ST_IDLE && in_valid) begin
      word <= in_data;
      accum <= (count != sbd_pkg::COUNT_MAX);
    end
    if (state == sbd_pkg::ST_MUL) begin
      prod <= frequency * word.sample_time_us;
    end
    if (state == sbd_pkg::ST_MOD) begin
      mod_q <= mod_p[44:30];
    end
    if (state == sbd_pkg::ST_MODFIX) begin
      ph_rem <= mod_ge ? mod_adj[29:0] : mod_rem[29:0];
    end
    if (state == sbd_pkg::ST_PHQ) begin
      ph_q <= ph_p[60:29];
    end
    if (state == sbd_pkg::ST_PHFIX) begin
      phase <= ph_ge ? ph_q + 32'd1 : ph_q;
    end
    if (state == sbd_pkg::ST_OUT && out_free) begin
      out_data.sample_count <= (count_w > 32'(sbd_pkg::OUT_MAX)) ? sbd_pkg::OUT_MAX
                                                                 : count_w[23:0];
      out_data.mag_x <= mag_all[0];
      out_data.mag_y <= mag_all[1];
      out_data.mag_z <= mag_all[2];
    end
  end

  // Every delivered result follows at least one accepted sample.
  `SBD_ASSERT(a_count_nonzero, out_valid |-> (out_data.sample_count != '0), "zero count on output")
  // The count advances by one exactly when a sample is accumulated.
  `SBD_ASSERT(a_count_step, (state == sbd_pkg::ST_LSTART && accum) |=> (count == $past(count) + 1'b1), "count did not advance")
  // A new word is only taken once the lanes have finished the last one.
  `SBD_ASSERT(a_lanes_idle, (in_valid && in_ready && out_valid) |-> (&lane_done), "word taken while lanes busy")
endmodule
`default_nettype wire

/* sim/single_bin_dft_three_axis_tb.sv */
// Self-checking testbench for the single-bin DFT tracker: directed table, then random words.
`timescale 1ns / 1ps
`default_nettype none
module single_bin_dft_three_axis_tb;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RAND_PER_PHASE = 330;
  localparam int HOLD_CYCLES = 3000;
  localparam longint unsigned NS_TURN = 64'd1000000000;
  localparam longint SUM_HI = (64'sd1 <<< 55) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< 55);
  localparam longint GAIN = 64'sd652032874;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  sbd_pkg::in_word_t in_data;
  sbd_pkg::out_word_t out_data;
  logic [sbd_pkg::FREQ_BITS-1:0] cfg_data;

  single_bin_dft_three_axis dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the accumulator state and the bin frequency.
  longint sine_sum [3];
  longint cosine_sum [3];
  longint unsigned taken;
  logic [sbd_pkg::FREQ_BITS-1:0] bin_freq;

  sbd_pkg::out_word_t pending_results[$];
  int errors;
  int in_idle_pct, out_idle_pct;
  bit hold_req;
  longint cycles;

  longint arctan_tbl [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  typedef struct {
    sbd_pkg::in_word_t w;
    bit fixed;
    sbd_pkg::out_word_t want;
  } dir_row_t;
  dir_row_t dir_tbl[$];

  // Rounds a Q2.30 value to Q1.15 with symmetric clamping.
  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  // Rotation CORDIC: sine and cosine of a 32-bit turn fraction.
  task automatic phase_trig(input logic [31:0] ph, output longint s, output longint c);
    longint x, y, z, dx, dy;
    logic [31:0] p;
    bit flip;
    x = GAIN; y = 0; p = ph; flip = 0;
    if (p >= 32'h4000_0000 && p < 32'hC000_0000) begin
      flip = 1;
      p = p - 32'h8000_0000;
    end
    z = $signed(p);
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tbl[i];
      end else begin
        x += dx; y -= dy; z += arctan_tbl[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = round_q15(y);
    c = round_q15(x);
  endtask

  // Vectoring CORDIC modulus scaled to twice the mean, Q16.8, saturating.
  function automatic logic [sbd_pkg::OUT_BITS-1:0] bin_amplitude(longint sp, longint cp,
                                                                longint unsigned n);
    longint x, y, dx, dy;
    longint unsigned u, d, a, r, q, v;
    if (n == 0) return '0;
    x = sp < 0 ? -sp : sp;
    y = cp < 0 ? -cp : cp;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy;
      end else begin
        x -= dx; y += dy;
      end
    end
    u = x;
    d = n << 6;
    a = u / d;
    r = u % d;
    if (a >= (64'd1 << 26)) return sbd_pkg::OUT_MAX;
    q = (r << 20) / d;
    v = (a * GAIN + ((q * GAIN) >> 20)) >> 30;
    return v > sbd_pkg::OUT_MAX ? sbd_pkg::OUT_MAX : v[sbd_pkg::OUT_BITS-1:0];
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  // Accumulates one sample set and returns the word the block should send.
  task automatic accumulate_sample(input sbd_pkg::in_word_t w, output sbd_pkg::out_word_t res);
    longint unsigned prod;
    logic [31:0] ph;
    longint s, c;
    longint smp [3];
    logic [sbd_pkg::OUT_BITS-1:0] mags [3];
    smp[0] = w.accel_x; smp[1] = w.accel_y; smp[2] = w.accel_z;
    if (taken < {40'd0, sbd_pkg::COUNT_MAX}) begin
      prod = (longint'(bin_freq) * longint'(w.sample_time_us)) % NS_TURN;
      ph = 32'((prod << 32) / NS_TURN);
      phase_trig(ph, s, c);
      for (int a = 0; a < 3; a++) begin
        sine_sum[a] = clamp_sum(sine_sum[a] + smp[a] * s);
        cosine_sum[a] = clamp_sum(cosine_sum[a] + smp[a] * c);
      end
      taken++;
    end
    for (int a = 0; a < 3; a++) mags[a] = bin_amplitude(sine_sum[a], cosine_sum[a], taken);
    res.sample_count = taken > sbd_pkg::OUT_MAX ? sbd_pkg::OUT_MAX
                                                : taken[sbd_pkg::OUT_BITS-1:0];
    res.mag_x = mags[0];
    res.mag_y = mags[1];
    res.mag_z = mags[2];
  endtask

  // Offers one word, records its expectation and returns at the accepting edge.
  task automatic offer_sample(input sbd_pkg::in_word_t w, input bit fixed,
                              input sbd_pkg::out_word_t want);
    sbd_pkg::out_word_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    accumulate_sample(w, res);
    pending_results.push_back(fixed ? want : res);
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Writes the bin frequency once the block has drained.
  task automatic set_frequency(input logic [sbd_pkg::FREQ_BITS-1:0] f);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= f;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    bin_freq = f;
  endtask

  function automatic sbd_pkg::in_word_t random_sample();
    sbd_pkg::in_word_t w;
    case ($urandom_range(3))
      0: w.sample_time_us = 24'($urandom_range(2000));
      1: w.sample_time_us = 24'($urandom_range(32'hFF_FFFF, 32'hFF_F000));
      default: w.sample_time_us = 24'($urandom);
    endcase
    w.accel_x = 16'($urandom);
    w.accel_y = 16'($urandom);
    w.accel_z = 16'($urandom);
    if ($urandom_range(9) == 0) w.accel_x = 16'sh8000;
    if ($urandom_range(9) == 0) w.accel_y = 16'sh7FFF;
    if ($urandom_range(9) == 0) w.accel_z = 16'sh0000;
    return w;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) offer_sample(random_sample(), 1'b0, '0);
  endtask

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side readiness, with one long hold-off on request.
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Result checker: out_valid and out_ready are stable at the falling edge.
  always @(negedge clk) begin
    sbd_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.sample_count !== want.sample_count) begin
          $display("%0t: sample_count expected %0d got %0d", $realtime,
                   want.sample_count, out_data.sample_count);
          errors++;
        end
        if (out_data.mag_x !== want.mag_x) begin
          $display("%0t: mag_x expected %0d got %0d", $realtime, want.mag_x, out_data.mag_x);
          errors++;
        end
        if (out_data.mag_y !== want.mag_y) begin
          $display("%0t: mag_y expected %0d got %0d", $realtime, want.mag_y, out_data.mag_y);
          errors++;
        end
        if (out_data.mag_z !== want.mag_z) begin
          $display("%0t: mag_z expected %0d got %0d", $realtime, want.mag_z, out_data.mag_z);
          errors++;
        end
      end
    end
  end

  // Builds one row of the directed table.
  task automatic add_row(input logic [23:0] t, input logic [15:0] ax, input logic [15:0] ay,
                         input logic [15:0] az, input bit fixed, input logic [23:0] cnt,
                         input logic [23:0] mx, input logic [23:0] my, input logic [23:0] mz);
    dir_row_t r;
    r.w = '{t, ax, ay, az};
    r.fixed = fixed;
    r.want = '{cnt, mx, my, mz};
    dir_tbl.push_back(r);
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1; in_valid = 1'b0; in_data = '0; cfg_valid = 1'b0; cfg_data = '0;
    errors = 0; cycles = 0; hold_req = 0; in_idle_pct = 0; out_idle_pct = 0;
    for (int a = 0; a < 3; a++) begin
      sine_sum[a] = 0; cosine_sum[a] = 0;
    end
    taken = 0;
    bin_freq = sbd_pkg::FREQ_RESET;

    // Zero samples right after reset give zero amplitudes; the rest are predicted.
    add_row(24'd0, 16'h0000, 16'h0000, 16'h0000, 1, 24'd1, 24'd0, 24'd0, 24'd0);
    add_row(24'hFFFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 24'd2, 24'd0, 24'd0, 24'd0);
    add_row(24'd0, 16'h8000, 16'h7FFF, 16'h0001, 0, 0, 0, 0, 0);
    add_row(24'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 0, 0, 0);
    add_row(24'd5, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
    add_row(24'd10, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0);
    add_row(24'd15, 16'h8000, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 0);
    add_row(24'd20000, 16'h1234, 16'hEDCB, 16'h5555, 0, 0, 0, 0, 0);
    add_row(24'hFFFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 0, 0, 0, 0, 0);
    add_row(24'h800000, 16'h7FFF, 16'h8000, 16'h0000, 0, 0, 0, 0, 0);
    add_row(24'h7FFFFF, 16'h0001, 16'hFFFF, 16'h8000, 0, 0, 0, 0, 0);
    add_row(24'd5000, 16'h4000, 16'hC000, 16'h2000, 0, 0, 0, 0, 0);
    add_row(24'd12500, 16'h4000, 16'hC000, 16'h2000, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset frequency.
    in_idle_pct = 22; out_idle_pct = 75;
    foreach (dir_tbl[i]) offer_sample(dir_tbl[i].w, dir_tbl[i].fixed, dir_tbl[i].want);
    set_frequency('0);
    run_random(20);
    set_frequency('1);
    run_random(RAND_PER_PHASE);

    // Swap the idling sides.
    set_frequency(sbd_pkg::FREQ_RESET);
    in_idle_pct = 75; out_idle_pct = 22;
    run_random(RAND_PER_PHASE);

    // No idling; the result side stalls long enough to back up the input.
    set_frequency(20'($urandom_range(1048575)));
    in_idle_pct = 0; out_idle_pct = 0;
    hold_req = 1;
    run_random(RAND_PER_PHASE);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
